// ===== rtl/core/pt64_pkg.sv =====
package pt64_pkg;

  localparam int WORD_BITS_DEF = 64;
  localparam int CAND_W = 64;
  localparam logic [63:0] SMALL_LIMIT = 64'd4759123141;
  localparam logic [2:0] SMALL_COUNT = 3'd3;
  localparam logic [2:0] LARGE_COUNT = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_BASE,
    S_POW,
    S_MSTART,
    S_MUL,
    S_CHECK,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    D_RES,
    D_BSQ,
    D_XSQ
  } dest_t;

  function automatic logic [63:0] base_val(input logic use_large, input logic [2:0] idx);
    logic [63:0] v;
    v = 64'd2;
    if (!use_large) begin
      unique case (idx)
        3'd0: v = 64'd2;
        3'd1: v = 64'd7;
        3'd2: v = 64'd61;
        default: v = 64'd2;
      endcase
    end else begin
      unique case (idx)
        3'd0: v = 64'd2;
        3'd1: v = 64'd325;
        3'd2: v = 64'd9375;
        3'd3: v = 64'd28178;
        3'd4: v = 64'd450775;
        3'd5: v = 64'd9780504;
        3'd6: v = 64'd1795265022;
        default: v = 64'd2;
      endcase
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/pt64_in_if.sv =====
interface pt64_in_if import pt64_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CAND_W-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

// ===== rtl/core/pt64_out_if.sv =====
interface pt64_out_if;
  logic valid;
  logic ready;
  logic prime;

  modport source (output valid, output prime, input ready);
  modport sink (input valid, input prime, output ready);
endinterface

// ===== rtl/core/primality_test_64_top.sv =====
// Deterministic Miller-Rabin primality test on an unsigned candidate.
// Input channel in_ch carries candidate; the low W bits are tested.
// Output channel out_ch carries prime, one transaction per input.
// One candidate is processed at a time: in_ch.ready is high only while
// the block is idle, and stays low until the result has been taken.
// All modular products run through one shared bit-serial multiplier
// that doubles once per operand bit and adds once more per set bit.
// A base costs at most about 2*W products, since the exponent bits and
// the squarings together number at most W; up to seven bases are tried.
// The result is offered in the cycle after acceptance for 0, 1, 2 and
// even inputs, and once the base tests have finished for the others.
// The next candidate is accepted the cycle after the result is taken.
// Reset is synchronous and active low and returns the block to idle.
// When the receiver stalls, out_ch.valid and prime hold until taken.
module primality_test_64_top import pt64_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  pt64_in_if.sink    in_ch,
  pt64_out_if.source out_ch
);

  localparam int W = WORD_BITS;
  localparam int SW = $clog2(W);

  state_t        state_r, state_nxt;
  dest_t         dest_r, dest_nxt;
  logic [W-1:0]  n_r, n_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [W-1:0]  e_r, e_nxt;
  logic [W-1:0]  res_r, res_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  x_r, x_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [SW-1:0] r_r, r_nxt;
  logic [2:0]    idx_r, idx_nxt;
  logic          large_r, large_nxt;
  logic          prime_r, prime_nxt;

  logic [W-1:0]  n_in;
  logic [63:0]   base;
  logic [2:0]    count;
  logic          mul_start;
  logic          mul_done;
  logic [W-1:0]  mul_x;
  logic [W-1:0]  mul_y;
  logic [W-1:0]  prod;

  assign n_in  = in_ch.candidate[W-1:0];
  assign base  = base_val(large_r, idx_r);
  assign count = large_r ? LARGE_COUNT : SMALL_COUNT;

  always_comb begin
    mul_x = x_r;
    mul_y = x_r;
    case (dest_r)
      D_RES: begin
        mul_x = res_r;
        mul_y = b_r;
      end
      D_BSQ: begin
        mul_x = b_r;
        mul_y = b_r;
      end
      default: begin
        mul_x = x_r;
        mul_y = x_r;
      end
    endcase
  end

  pt64_modmul #(.W(W)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_x    (mul_x),
    .op_y    (mul_y),
    .modulus (n_r),
    .done    (mul_done),
    .product (prod)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (n_in <= W'(2) || !n_in[0]) state_nxt = S_OUT;
          else state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (d_r[0]) state_nxt = S_BASE;
      end
      S_BASE: begin
        if (idx_r >= count || base >= 64'(n_r)) state_nxt = S_OUT;
        else state_nxt = S_POW;
      end
      S_POW: begin
        if (e_r == '0) begin
          if (res_r == W'(1)) state_nxt = S_BASE;
          else state_nxt = S_CHECK;
        end else begin
          state_nxt = S_MSTART;
        end
      end
      S_MSTART: state_nxt = S_MUL;
      S_MUL: begin
        if (mul_done) begin
          if (dest_r == D_RES) state_nxt = S_MSTART;
          else if (dest_r == D_BSQ) state_nxt = S_POW;
          else state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (r_r < s_r) begin
          if (x_r == n_r - W'(1)) state_nxt = S_BASE;
          else state_nxt = S_MSTART;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    dest_nxt  = dest_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    e_nxt     = e_r;
    res_nxt   = res_r;
    b_nxt     = b_r;
    x_nxt     = x_r;
    s_nxt     = s_r;
    r_nxt     = r_r;
    idx_nxt   = idx_r;
    large_nxt = large_r;
    prime_nxt = prime_r;
    mul_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        n_nxt     = n_in;
        d_nxt     = n_in - W'(1);
        s_nxt     = '0;
        idx_nxt   = '0;
        large_nxt = 64'(n_in) > SMALL_LIMIT;
        prime_nxt = (n_in == W'(2));
      end
      S_PREP: begin
        if (!d_r[0]) begin
          d_nxt = d_r >> 1;
          s_nxt = s_r + 1'b1;
        end
      end
      S_BASE: begin
        prime_nxt = 1'b1;
        res_nxt   = W'(1);
        b_nxt     = base[W-1:0];
        e_nxt     = d_r;
      end
      S_POW: begin
        if (e_r == '0) begin
          x_nxt = res_r;
          r_nxt = '0;
          if (res_r == W'(1)) idx_nxt = idx_r + 1'b1;
        end else if (e_r[0]) begin
          dest_nxt = D_RES;
        end else begin
          dest_nxt = D_BSQ;
        end
      end
      S_MSTART: mul_start = 1'b1;
      S_MUL: begin
        if (mul_done) begin
          unique case (dest_r)
            D_RES: begin
              res_nxt  = prod;
              dest_nxt = D_BSQ;
            end
            D_BSQ: begin
              b_nxt = prod;
              e_nxt = e_r >> 1;
            end
            default: begin
              x_nxt = prod;
              r_nxt = r_r + 1'b1;
            end
          endcase
        end
      end
      S_CHECK: begin
        dest_nxt = D_XSQ;
        if (r_r < s_r) begin
          if (x_r == n_r - W'(1)) idx_nxt = idx_r + 1'b1;
        end else begin
          prime_nxt = 1'b0;
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dest_r  <= D_RES;
    end else begin
      state_r <= state_nxt;
      dest_r  <= dest_nxt;
    end
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    e_r     <= e_nxt;
    res_r   <= res_nxt;
    b_r     <= b_nxt;
    x_r     <= x_nxt;
    s_r     <= s_nxt;
    r_r     <= r_nxt;
    idx_r   <= idx_nxt;
    large_r <= large_nxt;
    prime_r <= prime_nxt;
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.prime = prime_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input ready while result pending");
  a_prep_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PREP) |-> n_r[0])
    else $error("even candidate reached decomposition");
  a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_MUL))
    else $error("multiplier finished outside wait state");
  a_operands_lt_n: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (b_r < n_r && res_r < n_r))
    else $error("multiplier operand not reduced");

endmodule

// ===== rtl/core/pt64_modmul.sv =====
module pt64_modmul import pt64_pkg::*; #(
  parameter int W = WORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] op_x,
  input  logic [W-1:0] op_y,
  input  logic [W-1:0] modulus,
  output logic         done,
  output logic [W-1:0] product
);

  localparam int IW = $clog2(W);

  logic         busy_r, busy_nxt;
  logic         add_r, add_nxt;
  logic         done_r, done_nxt;
  logic [IW-1:0] bit_r, bit_nxt;
  logic [W-1:0] acc_r, acc_nxt;
  logic [W-1:0] add_b;
  logic [W:0]   sum;
  logic [W:0]   diff;
  logic [W-1:0] modsum;

  assign add_b  = add_r ? op_x : acc_r;
  assign sum    = {1'b0, acc_r} + {1'b0, add_b};
  assign diff   = sum - {1'b0, modulus};
  assign modsum = (sum >= {1'b0, modulus}) ? diff[W-1:0] : sum[W-1:0];

  always_comb begin
    busy_nxt = busy_r;
    add_nxt  = add_r;
    bit_nxt  = bit_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      add_nxt  = 1'b0;
      bit_nxt  = IW'(W - 1);
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = modsum;
      if (!add_r && op_y[bit_r]) begin
        add_nxt = 1'b1;
      end else begin
        add_nxt = 1'b0;
        if (bit_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      add_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      add_r  <= add_nxt;
      done_r <= done_nxt;
    end
    bit_r <= bit_nxt;
    acc_r <= acc_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("done while busy");
  a_add_busy: assert property (@(posedge clk) disable iff (!rst_n) add_r |-> busy_r)
    else $error("add phase while idle");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_r)
    else $error("start did not begin multiply");

endmodule

// ===== tb/sv/tb_primality_test_64_top.sv =====
`timescale 1ns / 1ps

module tb_primality_test_64_top;
  import pt64_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 200_000_000;
  localparam int N_RANDOM = 400;
  localparam int HOLD_AT = 150;
  localparam int HOLD_CYCLES = 3000;
  localparam logic [63:0] SMALL_BOUND = 64'd4759123141;

  logic clk;
  logic rst_n;

  pt64_in_if  in_if ();
  pt64_out_if out_if ();

  primality_test_64_top u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  logic [63:0] cand_q[$];
  bit          verdict_q[$];
  int          n_sent;
  int          n_checked;
  int          n_primes;
  int          n_errors;
  int          hold_left;
  bit          hold_done;
  longint unsigned cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y, logic [63:0] n);
    logic [127:0] prod;
    prod = {64'd0, x} * {64'd0, y};
    return 64'(prod % {64'd0, n});
  endfunction

  function automatic logic [63:0] mod_pow(logic [63:0] b, logic [63:0] e, logic [63:0] n);
    logic [63:0] acc;
    acc = 64'd1;
    while (e != 0) begin
      if (e[0]) acc = mod_mul(acc, b, n);
      b = mod_mul(b, b, n);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic bit witness_ok(logic [63:0] a, int s, logic [63:0] d, logic [63:0] n);
    logic [63:0] x;
    x = mod_pow(a, d, n);
    if (x == 64'd1) return 1'b1;
    for (int r = 0; r < s; r++) begin
      if (x == n - 64'd1) return 1'b1;
      x = mod_mul(x, x, n);
    end
    return 1'b0;
  endfunction

  function automatic bit predict_prime(logic [63:0] n);
    logic [63:0] d;
    logic [63:0] bases[7];
    int s;
    int cnt;
    s = 0;
    if (n <= 64'd1 || (n > 64'd2 && !n[0])) return 1'b0;
    if (n == 64'd2) return 1'b1;
    d = n - 64'd1;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    if (n <= SMALL_BOUND) begin
      bases = '{64'd2, 64'd7, 64'd61, 64'd0, 64'd0, 64'd0, 64'd0};
      cnt = 3;
    end else begin
      bases = '{64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504,
                64'd1795265022};
      cnt = 7;
    end
    for (int i = 0; i < cnt; i++) begin
      if (bases[i] >= n) break;
      if (!witness_ok(bases[i], s, d, n)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.candidate <= '0;
      n_sent <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        verdict_q.push_back(predict_prime(in_if.candidate));
        n_sent <= n_sent + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (cand_q.size() > 0 &&
            ((n_sent >= 100 && n_sent < 160) || $urandom_range(99) >= 14)) begin
          in_if.valid <= 1'b1;
          in_if.candidate <= cand_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // hold off the receiver once for a long stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_sent == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      n_checked <= 0;
      n_primes <= 0;
      n_errors <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected transaction, prime=%0b", $time, out_if.prime);
          n_errors <= n_errors + 1;
        end else begin
          if (out_if.prime !== verdict_q[0]) begin
            $display("%0t: prime mismatch, expected %0b actual %0b", $time,
                     verdict_q[0], out_if.prime);
            n_errors <= n_errors + 1;
          end
          n_primes <= n_primes + int'(verdict_q[0]);
          void'(verdict_q.pop_front());
        end
        n_checked <= n_checked + 1;
      end
      if (hold_left > 0)
        out_if.ready <= 1'b0;
      else
        out_if.ready <= ((n_checked >= 100 && n_checked < 160) ||
                         $urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, verdict_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] v;
    logic [63:0] known_primes[8];
    int pick;
    known_primes = '{64'd1000000007, 64'd998244353, 64'd4294967291, 64'd4294967311,
                     64'd2305843009213693951, 64'd9223372036854775783,
                     64'd18446744073709551557, 64'd4759123129};
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    cand_q = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd7, 64'd9, 64'd61,
               64'd63, 64'd561, 64'd3215031751, 64'd4759123141, 64'd4759123139,
               64'd4759123143, 64'd2152302898747, 64'd2305843009213693951,
               64'd18446744073709551557, 64'd18446744073709551615,
               64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
               64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB};

    // pause until the directed part has drained
    wait (cand_q.size() == 0 && !in_if.valid && verdict_q.size() == 0);
    @(posedge clk);

    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(99);
      if (pick < 30)
        v = {$urandom, $urandom} & ~64'd1;
      else if (pick < 70)
        v = 64'($urandom_range(1 << 20)) | 64'd1;
      else if (pick < 88)
        v = {$urandom, $urandom} | 64'd1;
      else if (pick < 94)
        v = known_primes[$urandom_range(7)];
      else
        v = 64'({1'b1, 31'($urandom)} | 32'd1) * 64'({1'b1, 31'($urandom)} | 32'd1);
      cand_q.push_back(v);
    end

    wait (cand_q.size() == 0 && !in_if.valid && verdict_q.size() == 0);
    repeat (50) @(posedge clk);
    $display("Checked %0d verdicts (%0d prime) over %0d candidates in %0d cycles.",
             n_checked, n_primes, n_sent, cycles);
    $display("Covered trivial, small-base, large-base, pseudoprime and boundary cases.");
    if (n_errors == 0 && verdict_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
